>>> rtl/round_robin_completion_times_macros.svh
// Assertion macros shared by the round-robin completion time checker
`ifndef ROUND_ROBIN_COMPLETION_TIMES_MACROS_SVH
`define ROUND_ROBIN_COMPLETION_TIMES_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RRCT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rrct assertion failed");

// antecedent implies consequent in the next cycle
`define RRCT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rrct assertion failed");

`endif

>>> rtl/rrct_pkg.sv
// Shared types and constants for the round-robin completion time block
package rrct_pkg;

	localparam int MAX_JOBS_DEF = 16;
	localparam int TIME_W       = 16;
	localparam int CT_W         = 22;
	localparam int TAT_W        = 23;
	localparam int JOBNUM_W     = 7;
	localparam logic [TIME_W-1:0] QUANTUM_RST = 16'd4;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PASS_RD,
		ST_PASS_EX,
		ST_OUT_RD,
		ST_OUT_EX
	} rrct_state_t;

	typedef struct packed {
		logic              ld_en;
		logic              rem_en;
		logic              cmp_en;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
		logic [TIME_W-1:0] remaining;
		logic [CT_W-1:0]   completion;
	} tbl_wr_t;

	typedef struct packed {
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
		logic [TIME_W-1:0] remaining;
		logic [CT_W-1:0]   completion;
	} tbl_rd_t;

endpackage

>>> rtl/round_robin_completion_times.sv
// Round-robin completion time calculator, top level
// Jobs load one per cycle (s_tdata = arrival, burst; s_tlast marks the final job)
// until s_tlast, then s_tready drops while the job table is walked in load order:
// each job's step in a pass is a registered table read, then one compare,
// subtract and add in the shared slice unit, and P = ceil(max burst / quantum) + 1
// passes run. Results follow in load order, each after its own table read, and
// stall while m_tready is low. A quantum of zero acts as one; jobs beyond MAX_JOBS
// are dropped. The quantum may only be written while idle.
module round_robin_completion_times #(
	parameter int MAX_JOBS = rrct_pkg::MAX_JOBS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        time_quantum_we,
	input  logic [rrct_pkg::TIME_W-1:0] time_quantum,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [31:0]                 s_tdata,  // arrival_time, burst_time
	input  logic                        s_tlast,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// job_number, completion_time, turnaround_time, waiting_time, zero pad
	output logic [79:0]                 m_tdata,
	output logic                        m_tlast
);
	import rrct_pkg::*;

	localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

	logic [IDX_W-1:0]    wr_idx, rd_idx;
	tbl_wr_t             wr;
	tbl_rd_t             rd;
	logic [JOBNUM_W-1:0] job_number;
	logic [CT_W-1:0]     completion;
	logic [TAT_W-1:0]    turnaround, waiting;

	rrct_ctrl #(.MAX_JOBS(MAX_JOBS), .IDX_W(IDX_W)) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.time_quantum_we(time_quantum_we),
		.time_quantum   (time_quantum),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.in_arrival     (s_tdata[15:0]),
		.in_burst       (s_tdata[31:16]),
		.in_last        (s_tlast),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_job_number (job_number),
		.out_completion (completion),
		.out_turnaround (turnaround),
		.out_waiting    (waiting),
		.out_last       (m_tlast),
		.wr_idx         (wr_idx),
		.wr             (wr),
		.rd_idx         (rd_idx),
		.rd             (rd)
	);

	rrct_table #(.MAX_JOBS(MAX_JOBS), .IDX_W(IDX_W)) u_table (
		.clk   (clk),
		.wr_idx(wr_idx),
		.wr    (wr),
		.rd_idx(rd_idx),
		.rd    (rd)
	);

	assign m_tdata = {5'b0, waiting, turnaround, completion, job_number};

endmodule

>>> rtl/rrct_table.sv
// Job table memories: one write port, one registered read port
module rrct_table #(
	parameter int MAX_JOBS = rrct_pkg::MAX_JOBS_DEF,
	parameter int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1
) (
	input  logic             clk,
	input  logic [IDX_W-1:0] wr_idx,
	input  rrct_pkg::tbl_wr_t wr,
	input  logic [IDX_W-1:0] rd_idx,
	output rrct_pkg::tbl_rd_t rd
);
	import rrct_pkg::*;

	logic [TIME_W-1:0] arrival_mem   [MAX_JOBS];
	logic [TIME_W-1:0] burst_mem     [MAX_JOBS];
	logic [TIME_W-1:0] remaining_mem [MAX_JOBS];
	logic [CT_W-1:0]   completion_mem[MAX_JOBS];

	always_ff @(posedge clk) begin
		if (wr.ld_en) begin
			arrival_mem[wr_idx] <= wr.arrival;
			burst_mem[wr_idx]   <= wr.burst;
		end
		if (wr.ld_en || wr.rem_en) begin
			remaining_mem[wr_idx] <= wr.remaining;
		end
		if (wr.ld_en || wr.cmp_en) begin
			completion_mem[wr_idx] <= wr.completion;
		end
	end

	always_ff @(posedge clk) begin
		rd.arrival    <= arrival_mem[rd_idx];
		rd.burst      <= burst_mem[rd_idx];
		rd.remaining  <= remaining_mem[rd_idx];
		rd.completion <= completion_mem[rd_idx];
	end

endmodule

>>> rtl/rrct_ctrl.sv
// Sequencer with the shared time-slice unit and the result register
module rrct_ctrl #(
	parameter int MAX_JOBS = rrct_pkg::MAX_JOBS_DEF,
	parameter int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        time_quantum_we,
	input  logic [rrct_pkg::TIME_W-1:0] time_quantum,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [rrct_pkg::TIME_W-1:0] in_arrival,
	input  logic [rrct_pkg::TIME_W-1:0] in_burst,
	input  logic                        in_last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rrct_pkg::JOBNUM_W-1:0] out_job_number,
	output logic [rrct_pkg::CT_W-1:0]   out_completion,
	output logic [rrct_pkg::TAT_W-1:0]  out_turnaround,
	output logic [rrct_pkg::TAT_W-1:0]  out_waiting,
	output logic                        out_last,
	output logic [IDX_W-1:0]            wr_idx,
	output rrct_pkg::tbl_wr_t           wr,
	output logic [IDX_W-1:0]            rd_idx,
	input  rrct_pkg::tbl_rd_t           rd
);
	import rrct_pkg::*;

	localparam int CNT_W = $clog2(MAX_JOBS + 1);

	rrct_state_t       state_q, state_d;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  count_q;
	logic [CT_W-1:0]   elapsed_q;
	logic              busy_q;
	logic [TIME_W-1:0] quantum_q;

	logic [TIME_W-1:0] q_eff;
	logic              rem_nz, rem_gt;
	logic [TIME_W-1:0] step;
	logic [CT_W-1:0]   elapsed_nx;
	logic              idx_is_last, out_free, table_full;
	logic              in_fire, pass_step, out_load;
	logic [TAT_W-1:0]  tat;

	assign q_eff       = (quantum_q == '0) ? TIME_W'(1) : quantum_q;
	assign rem_nz      = (rd.remaining != '0);
	assign rem_gt      = (rd.remaining > q_eff);
	assign step        = rem_gt ? q_eff : rd.remaining;
	assign elapsed_nx  = elapsed_q + CT_W'(step);
	assign idx_is_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign out_free    = !out_valid || out_ready;
	assign table_full  = (count_q == CNT_W'(MAX_JOBS));
	assign in_fire     = in_valid && in_ready;
	assign rd_idx      = idx_q;
	assign tat         = TAT_W'(rd.completion) - TAT_W'(rd.arrival);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		pass_step = 1'b0;
		out_load  = 1'b0;
		wr_idx    = idx_q;
		wr        = '0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready      = 1'b1;
				wr_idx        = count_q[IDX_W-1:0];
				wr.ld_en      = in_valid && !table_full;
				wr.arrival    = in_arrival;
				wr.burst      = in_burst;
				wr.remaining  = in_burst;
				wr.completion = '0;
				if (in_valid && in_last) begin
					state_d = ST_PASS_RD;
				end
			end
			ST_PASS_RD: begin
				state_d = ST_PASS_EX;
			end
			ST_PASS_EX: begin
				pass_step     = 1'b1;
				wr.rem_en     = rem_nz;
				wr.cmp_en     = rem_nz && !rem_gt;
				wr.remaining  = rem_gt ? (rd.remaining - q_eff) : '0;
				wr.completion = elapsed_nx;
				if (idx_is_last && !busy_q && !rem_nz) begin
					state_d = ST_OUT_RD;
				end else begin
					state_d = ST_PASS_RD;
				end
			end
			ST_OUT_RD: begin
				if (out_free) begin
					state_d = ST_OUT_EX;
				end
			end
			ST_OUT_EX: begin
				out_load = 1'b1;
				state_d  = idx_is_last ? ST_LOAD : ST_OUT_RD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			count_q   <= '0;
			elapsed_q <= '0;
			busy_q    <= 1'b0;
			quantum_q <= QUANTUM_RST;
			out_valid <= 1'b0;
		end else begin
			if (time_quantum_we) begin
				quantum_q <= time_quantum;
			end
			if (in_fire) begin
				if (!table_full) begin
					count_q <= count_q + CNT_W'(1);
				end
				if (in_last) begin
					idx_q     <= '0;
					elapsed_q <= '0;
					busy_q    <= 1'b0;
				end
			end
			if (pass_step) begin
				if (rem_nz) begin
					elapsed_q <= elapsed_nx;
				end
				if (idx_is_last) begin
					idx_q  <= '0;
					busy_q <= 1'b0;
				end else begin
					idx_q  <= idx_q + IDX_W'(1);
					busy_q <= busy_q || rem_nz;
				end
			end
			if (out_load) begin
				if (idx_is_last) begin
					count_q <= '0;
					idx_q   <= '0;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_job_number <= JOBNUM_W'(idx_q) + JOBNUM_W'(1);
			out_completion <= rd.completion;
			out_turnaround <= tat;
			out_waiting    <= tat - TAT_W'(rd.burst);
			out_last       <= idx_is_last;
		end
	end

endmodule

>>> rtl/rrct_checker.sv
// Port-level checker for the round-robin completion time block, with bind
`include "round_robin_completion_times_macros.svh"

module rrct_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata,
	input logic        m_tlast
);

	`RRCT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`RRCT_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
	`RRCT_ASSERT_SAME(a_no_load_mid_results, m_tvalid && !m_tlast, !s_tready)
	`RRCT_ASSERT_NEXT(a_busy_after_last, s_tvalid && s_tready && s_tlast, !s_tready)
	`RRCT_ASSERT_SAME(a_job_number_nonzero, m_tvalid, m_tdata[6:0] != 7'd0)

endmodule

bind round_robin_completion_times rrct_checker u_rrct_checker (.*);

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Testbench for round_robin_completion_times: job sets in, per-job time reports checked
module testbench;
	import rrct_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT    = 13;

	typedef struct packed {
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
		logic              last;
	} job_t;

	typedef struct packed {
		logic [JOBNUM_W-1:0] num;
		logic [CT_W-1:0]     completion;
		logic [TAT_W-1:0]    turnaround;
		logic [TAT_W-1:0]    waiting;
		logic                last;
	} times_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                time_quantum_we = 1'b0;
	logic [TIME_W-1:0]   time_quantum = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [31:0]         s_tdata = '0;  // arrival_time, burst_time
	logic                s_tlast = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [79:0]         m_tdata;       // job_number, completion, turnaround, waiting, pad
	logic                m_tlast;

	job_t                jobs_to_send[$];
	times_t              expected_times[$];
	job_t                cur_job;
	logic                steady = 1'b0;
	logic [TIME_W-1:0]   quantum_model = QUANTUM_RST;
	logic [TIME_W-1:0]   tbl_arrival[MAX_JOBS_DEF];
	logic [TIME_W-1:0]   tbl_burst[MAX_JOBS_DEF];
	int                  table_fill = 0;
	int                  mismatches = 0;
	int                  jobs_loaded = 0;
	int                  reports_seen = 0;
	int                  job_sets = 0;
	int                  quanta_used = 1;
	int                  cycle = 0;

	round_robin_completion_times dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.time_quantum_we (time_quantum_we),
		.time_quantum    (time_quantum),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast)
	);

	always #6 clk = ~clk;

	// store the job; on the last one run the round-robin walk and queue the reports
	task automatic load_job(input job_t j);
		logic [TIME_W-1:0] rem[MAX_JOBS_DEF];
		logic [CT_W-1:0]   done_at[MAX_JOBS_DEF];
		logic [CT_W-1:0]   clock_now;
		logic [TIME_W-1:0] slice;
		logic              busy;
		times_t            t;
		int                k;
		if (table_fill < MAX_JOBS_DEF) begin
			tbl_arrival[table_fill] = j.arrival;
			tbl_burst[table_fill] = j.burst;
			table_fill++;
		end
		if (j.last) begin
			slice = (quantum_model == '0) ? TIME_W'(1) : quantum_model;
			for (k = 0; k < table_fill; k++) begin
				rem[k] = tbl_burst[k];
				done_at[k] = '0;
			end
			clock_now = '0;
			busy = 1'b1;
			while (busy) begin
				busy = 1'b0;
				for (k = 0; k < table_fill; k++) begin
					if (rem[k] != '0) begin
						busy = 1'b1;
						if (rem[k] > slice) begin
							clock_now = clock_now + CT_W'(slice);
							rem[k] = rem[k] - slice;
						end else begin
							clock_now = clock_now + CT_W'(rem[k]);
							rem[k] = '0;
							done_at[k] = clock_now;
						end
					end
				end
			end
			for (k = 0; k < table_fill; k++) begin
				t.num = JOBNUM_W'(k + 1);
				t.completion = done_at[k];
				t.turnaround = {1'b0, done_at[k]} - TAT_W'(tbl_arrival[k]);
				t.waiting = t.turnaround - TAT_W'(tbl_burst[k]);
				t.last = (k == table_fill - 1);
				expected_times.push_back(t);
			end
			table_fill = 0;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				load_job(cur_job);
				jobs_loaded++;
			end
			if (!s_tvalid || s_tready) begin
				if (jobs_to_send.size() != 0 &&
				    (steady || $urandom_range(99) >= IDLE_PCT)) begin
					cur_job = jobs_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {cur_job.burst, cur_job.arrival};
					s_tlast <= cur_job.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		times_t want;
		times_t got;
		if (arst_n) begin
			m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
			if (m_tvalid && m_tready) begin
				reports_seen++;
				got.num = m_tdata[6:0];
				got.completion = m_tdata[28:7];
				got.turnaround = m_tdata[51:29];
				got.waiting = m_tdata[74:52];
				got.last = m_tlast;
				if (expected_times.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected report: job %0d ct %0d", got.num, got.completion);
				end else begin
					want = expected_times.pop_front();
					if (got.num != want.num || got.completion != want.completion ||
					    got.turnaround != want.turnaround || got.waiting != want.waiting ||
					    got.last != want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp job %0d ct %0d tat %0d wt %0d last %0b",
								" / got job %0d ct %0d tat %0d wt %0d last %0b"},
								want.num, want.completion, $signed(want.turnaround),
								$signed(want.waiting), want.last, got.num, got.completion,
								$signed(got.turnaround), $signed(got.waiting), got.last);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle);
			$display("status: fail");
			$finish;
		end
	end

	task automatic add_job(input int arrival, input int burst, input logic last);
		job_t j;
		j.arrival = TIME_W'(arrival);
		j.burst = TIME_W'(burst);
		j.last = last;
		jobs_to_send.push_back(j);
		if (last)
			job_sets++;
	endtask

	task automatic drain();
		while (jobs_to_send.size() != 0 || s_tvalid || expected_times.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_quantum(input logic [TIME_W-1:0] value);
		drain();
		@(posedge clk);
		time_quantum_we <= 1'b1;
		time_quantum <= value;
		@(posedge clk);
		time_quantum_we <= 1'b0;
		quantum_model = value;
		quanta_used++;
	endtask

	function automatic int rand_burst(input int cap);
		if ($urandom_range(9) == 0)
			return 0;
		if (cap >= 65535 && $urandom_range(7) == 0)
			return 65535;
		return $urandom_range(cap, 1);
	endfunction

	task automatic random_phase(input logic [TIME_W-1:0] q);
		int cap;
		int stored;
		int n;
		int k;
		write_quantum(q);
		cap = ((q == 0) ? 1 : int'(q)) * 40;
		if (cap > 65535)
			cap = 65535;
		stored = 0;
		while (stored < 8) begin
			n = ($urandom_range(6) == 0) ? $urandom_range(20, 17) : $urandom_range(16, 1);
			for (k = 0; k < n; k++)
				add_job($urandom_range(65535), rand_burst(cap), k == n - 1);
			stored += (n > MAX_JOBS_DEF) ? MAX_JOBS_DEF : n;
		end
		drain();
	endtask

	initial begin
		int k;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset quantum; table overflow with the last flag on a dropped item
		for (k = 0; k < 16; k++)
			add_job((k == 0) ? 0 : (k == 1) ? 65535 : $urandom_range(65535),
				(k % 5 == 0) ? 0 : k * 2 + 1, 1'b0);
		add_job(777, 9, 1'b1);
		add_job(65535, 0, 1'b1);
		add_job(0, 4, 1'b0);
		add_job(3, 5, 1'b1);
		drain();

		write_quantum(16'hFFFF);
		add_job(0, 65535, 1'b0);
		add_job(65535, 65535, 1'b0);
		add_job(12345, 0, 1'b0);
		add_job(1, 65534, 1'b1);
		drain();

		random_phase(16'd1);
		random_phase(16'd0);
		steady = 1'b1;
		random_phase(16'($urandom_range(16, 2)));
		steady = 1'b0;
		random_phase(16'($urandom_range(4095, 17)));
		random_phase(16'($urandom_range(65534, 4096)));
		random_phase(16'hFFFF);

		drain();
		repeat (20) @(posedge clk);
		if (expected_times.size() != 0)
			mismatches++;
		$display("%0d jobs in %0d sets over %0d quantum settings, %0d reports checked",
			jobs_loaded, job_sets, quanta_used, reports_seen);
		$display("including table overflow, zero bursts, zero and extreme quanta; %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rrct_pkg.sv
rtl/rrct_table.sv
rtl/rrct_ctrl.sv
rtl/round_robin_completion_times.sv
rtl/rrct_checker.sv
dv/testbench.sv
